### design/clbs_pkg.sv
package clbs_pkg;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int DISP_W     = 2;
    localparam int COL_W      = 6;
    localparam int NUM_W      = 32;

    // Decimal digits held by the BCD converter (enough for any 32-bit value)
    localparam int BCD_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);

    // Configuration port
    localparam int CFG_REGS   = 8;
    localparam int APB_ADDR_W = $clog2(CFG_REGS * 4);
    localparam int APB_DATA_W = 32;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_CMD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_DATA = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GOTO    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DECIMAL = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BINARY  = 3'd6;

    // Register indexes
    localparam logic [2:0] REG_FOUR_BIT  = 3'd0;
    localparam logic [2:0] REG_TWO_LINES = 3'd1;
    localparam logic [2:0] REG_FONT      = 3'd2;
    localparam logic [2:0] REG_DISP_ON   = 3'd3;
    localparam logic [2:0] REG_CURSOR    = 3'd4;
    localparam logic [2:0] REG_BLINK     = 3'd5;
    localparam logic [2:0] REG_INCREMENT = 3'd6;
    localparam logic [2:0] REG_SHIFT     = 3'd7;

    // Controller instruction bytes
    localparam logic [7:0] LCD_FSET8   = 8'b0011_0000;
    localparam logic [7:0] LCD_FSET4   = 8'b0010_0000;
    localparam logic [7:0] LCD_DISPCTL = 8'b0000_1000;
    localparam logic [7:0] LCD_ENTRY   = 8'b0000_0100;
    localparam logic [7:0] LCD_HOME4   = 8'b0000_0010;
    localparam logic [7:0] LCD_CLEAR   = 8'b0000_0001;
    localparam logic [7:0] LCD_DDRAM   = 8'h80;

    // Characters
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_B     = 8'h62;

    typedef struct packed {
        logic four_bit_bus;
        logic two_lines;
        logic large_font;
        logic display_on;
        logic cursor_on;
        logic blink_on;
        logic increment_cursor;
        logic shift_display;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        four_bit_bus:     1'b0,
        two_lines:        1'b1,
        large_font:       1'b0,
        display_on:       1'b1,
        cursor_on:        1'b0,
        blink_on:         1'b0,
        increment_cursor: 1'b1,
        shift_display:    1'b0
    };

    // One bus word from the sequencer to the strobe stage
    typedef struct packed {
        logic [DISP_W-1:0] disp;
        logic              rs;
        logic [7:0]        data;
        logic              wait_first;
        logic              last;
    } bus_word_t;

endpackage

### design/clbs_intf.sv
// Request channel
interface clbs_req_if;
    import clbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DISP_W-1:0] display;
    logic [7:0]        byte_value;
    logic              row;
    logic [COL_W-1:0]  column;
    logic [NUM_W-1:0]  number;

    modport source (
        output valid, command, display, byte_value, row, column, number,
        input  ready
    );

    modport sink (
        input  valid, command, display, byte_value, row, column, number,
        output ready
    );
endinterface

// Strobe channel
interface clbs_strobe_if;
    import clbs_pkg::*;

    logic              valid;
    logic              ready;
    logic [DISP_W-1:0] target_display;
    logic              register_select;
    logic [7:0]        bus_lines;
    logic              power_up_wait;
    logic              last;

    modport source (
        output valid, target_display, register_select, bus_lines, power_up_wait, last,
        input  ready
    );

    modport sink (
        input  valid, target_display, register_select, bus_lines, power_up_wait, last,
        output ready
    );
endinterface

### design/clbs_cfg_regs.sv
module clbs_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clbs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [clbs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [clbs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output clbs_pkg::cfg_t                      cfg
);
    import clbs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;
    logic       rd_bit;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // word address; byte offset within a register is don't-care
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_FOUR_BIT:  cfg_next.four_bit_bus     = pwdata[0];
                REG_TWO_LINES: cfg_next.two_lines        = pwdata[0];
                REG_FONT:      cfg_next.large_font       = pwdata[0];
                REG_DISP_ON:   cfg_next.display_on       = pwdata[0];
                REG_CURSOR:    cfg_next.cursor_on        = pwdata[0];
                REG_BLINK:     cfg_next.blink_on         = pwdata[0];
                REG_INCREMENT: cfg_next.increment_cursor = pwdata[0];
                REG_SHIFT:     cfg_next.shift_display    = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read decode
    always_comb
    begin
        unique case (reg_idx)
            REG_FOUR_BIT:  rd_bit = cfg_reg.four_bit_bus;
            REG_TWO_LINES: rd_bit = cfg_reg.two_lines;
            REG_FONT:      rd_bit = cfg_reg.large_font;
            REG_DISP_ON:   rd_bit = cfg_reg.display_on;
            REG_CURSOR:    rd_bit = cfg_reg.cursor_on;
            REG_BLINK:     rd_bit = cfg_reg.blink_on;
            REG_INCREMENT: rd_bit = cfg_reg.increment_cursor;
            REG_SHIFT:     rd_bit = cfg_reg.shift_display;
            default:       rd_bit = 1'b0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-1){1'b0}}, rd_bit};
    assign cfg    = cfg_reg;

endmodule

### design/clbs_bcd_unit.sv
module clbs_bcd_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [clbs_pkg::NUM_W-1:0]         number,
    output logic                               busy,
    input  logic [clbs_pkg::DIG_IDX_W-1:0]     rd_idx,
    output logic [3:0]                         rd_digit
);
    import clbs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]               bin_reg;
    logic [BCD_DIGITS-1:0][3:0]     bcd_reg;
    logic [BCD_DIGITS-1:0][3:0]     bcd_adj;
    logic [BCD_DIGITS-1:0][3:0]     bcd_next;
    logic [CNT_W-1:0]               cnt_reg;

    // add-3 correction on every digit, then shift in the next binary bit
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        // top bit of the top digit is always zero for a 32-bit value
        bcd_next = {bcd_adj[BCD_DIGITS-1][2:0], bcd_adj[BCD_DIGITS-2:0], bin_reg[NUM_W-1]};
    end

    // bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= number;
            bcd_reg <= '0;
        end
        else if (busy)
        begin
            bin_reg <= {bin_reg[NUM_W-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign rd_digit = bcd_reg[rd_idx];

endmodule

### design/clbs_bus_emitter.sv
module clbs_bus_emitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   four_bit,
    input  logic                   word_valid,
    input  clbs_pkg::bus_word_t    word,
    output logic                   word_ready,
    clbs_strobe_if.source          strobe
);
    import clbs_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    logic      pend_lo_reg;
    logic      pend_lo_next;
    bus_word_t out_reg;
    logic [3:0] lo_data_reg;
    logic      lo_last_reg;
    logic      load;
    logic      take;

    assign take       = out_valid_reg & strobe.ready;
    assign word_ready = ~out_valid_reg | (strobe.ready & ~pend_lo_reg);
    assign load       = word_valid & word_ready;

    // output valid and pending low nibble
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_lo_next   = pend_lo_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            pend_lo_next   = four_bit;
        end
        else if (take)
        begin
            if (pend_lo_reg)
            begin
                pend_lo_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_lo_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_lo_reg   <= pend_lo_next;
        end
    end

    // payload: whole byte, or high nibble then low nibble on D4..D7
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.disp       <= word.disp;
            out_reg.rs         <= word.rs;
            out_reg.data       <= four_bit ? {word.data[7:4], 4'b0000} : word.data;
            out_reg.wait_first <= word.wait_first;
            out_reg.last       <= four_bit ? 1'b0 : word.last;
            lo_data_reg        <= word.data[3:0];
            lo_last_reg        <= word.last;
        end
        else if (take && pend_lo_reg)
        begin
            out_reg.data       <= {lo_data_reg, 4'b0000};
            out_reg.wait_first <= 1'b0;
            out_reg.last       <= lo_last_reg;
        end
    end

    assign strobe.valid           = out_valid_reg;
    assign strobe.target_display  = out_reg.disp;
    assign strobe.register_select = out_reg.rs;
    assign strobe.bus_lines       = out_reg.data;
    assign strobe.power_up_wait   = out_reg.wait_first;
    assign strobe.last            = out_reg.last;

`ifndef NO_ASSERTIONS
    a_pend_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_lo_reg |-> out_valid_reg)
        else $error("low nibble pending without a held strobe");

    a_lo_follows_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (take && pend_lo_reg) |=> (strobe.valid && !strobe.power_up_wait))
        else $error("low nibble strobe missing or flagged for power-up wait");
`endif

endmodule

### design/char_lcd_bus_sequencer.sv
// Character display bus sequencer. Each request (init, command, data, clear,
// goto, decimal print, binary print) is turned into a series of enable
// strobes, one word on the strobe channel per strobe. A new request is taken
// only when the sequencer is idle. The sequencer hands one bus byte per cycle
// to the strobe stage while that stage is ready for it; in 8-bit mode each
// byte is one strobe, in 4-bit mode two strobes. Init sends 4 bytes in 8-bit
// mode and 5 in 4-bit mode, binary print 10 bytes, and command, data, clear
// and goto requests one byte each. A decimal print first runs the
// shift-and-add-3 converter, then scans off leading zeros at one digit per
// cycle, then emits the digits. When DECIMAL_DIGITS cuts a number short,
// the kept low digits are printed as they are, zeros included. Requests
// with an unknown code or a display number not below DISPLAYS are accepted
// and dropped without a strobe. There is no clearing pass after reset.
module char_lcd_bus_sequencer #(
    parameter int DISPLAYS       = 4,
    parameter int DECIMAL_DIGITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    clbs_req_if.sink                          request,
    clbs_strobe_if.source                     strobe,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [clbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [clbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import clbs_pkg::*;

    localparam int NDIG   = (DECIMAL_DIGITS < BCD_DIGITS) ? DECIMAL_DIGITS : BCD_DIGITS;
    localparam int STEP_W = 4;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LIST   = 3'd1;
    localparam logic [2:0] ST_CONV   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DIGITS = 3'd4;

    cfg_t                 cfg;
    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [DIG_IDX_W-1:0] dig_reg;
    logic [DIG_IDX_W-1:0] dig_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [DISP_W-1:0]    disp_reg;
    logic [7:0]           val_reg;
    logic                 row_reg;
    logic [COL_W-1:0]     col_reg;

    logic                 req_fire;
    logic                 req_ok;
    logic                 bcd_start;
    logic                 bcd_busy;
    logic [3:0]           bcd_digit;

    logic                 word_valid;
    logic                 word_ready;
    logic                 word_fire;
    bus_word_t            word;
    logic [STEP_W-1:0]    list_last;
    logic                 last_step;
    logic [STEP_W-1:0]    init_idx;
    logic [7:0]           init_byte;
    logic [7:0]           list_byte;
    logic [2:0]           bit_sel;

    clbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clbs_bcd_unit u_bcd (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (bcd_start),
        .number   (request.number),
        .busy     (bcd_busy),
        .rd_idx   (dig_reg),
        .rd_digit (bcd_digit)
    );

    clbs_bus_emitter u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .four_bit   (cfg.four_bit_bus),
        .word_valid (word_valid),
        .word       (word),
        .word_ready (word_ready),
        .strobe     (strobe)
    );

    // request intake
    assign request.ready = (state_reg == ST_IDLE);
    assign req_fire      = request.valid & request.ready;
    assign req_ok        = (int'(request.display) < DISPLAYS) && (request.command <= CMD_BINARY);
    assign bcd_start     = req_fire & req_ok & (request.command == CMD_DECIMAL);

    // length of the byte list for list-type requests
    always_comb
    begin
        case (cmd_reg)
            CMD_INIT:   list_last = cfg.four_bit_bus ? STEP_W'(4) : STEP_W'(3);
            CMD_BINARY: list_last = STEP_W'(9);
            default:    list_last = '0;
        endcase
    end
    assign last_step = (step_reg == list_last);

    // init bytes; 8-bit mode skips the leading 4-bit switch byte
    assign init_idx = cfg.four_bit_bus ? step_reg : step_reg + 1'b1;

    always_comb
    begin
        case (init_idx)
            STEP_W'(0): init_byte = LCD_HOME4;
            STEP_W'(1): init_byte = (cfg.four_bit_bus ? LCD_FSET4 : LCD_FSET8)
                                    | {4'b0000, cfg.two_lines, cfg.large_font, 2'b00};
            STEP_W'(2): init_byte = LCD_DISPCTL
                                    | {5'b00000, cfg.display_on, cfg.cursor_on, cfg.blink_on};
            STEP_W'(3): init_byte = LCD_CLEAR;
            default:    init_byte = LCD_ENTRY
                                    | {6'b000000, cfg.increment_cursor, cfg.shift_display};
        endcase
    end

    // binary print: '0', 'b', then bits 7 down to 0
    assign bit_sel = 3'(STEP_W'(9) - step_reg);

    always_comb
    begin
        case (cmd_reg)
            CMD_INIT:  list_byte = init_byte;
            CMD_CLEAR: list_byte = LCD_CLEAR;
            CMD_GOTO:  list_byte = LCD_DDRAM | {1'b0, row_reg, col_reg};
            CMD_BINARY:
            begin
                if (step_reg == '0)
                begin
                    list_byte = ASCII_ZERO;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    list_byte = ASCII_B;
                end
                else
                begin
                    list_byte = ASCII_ZERO | {7'b0000000, val_reg[bit_sel]};
                end
            end
            default:   list_byte = val_reg;
        endcase
    end

    // word to the strobe stage
    assign word_valid      = (state_reg == ST_LIST) || (state_reg == ST_DIGITS);
    assign word_fire       = word_valid & word_ready;
    assign word.disp       = disp_reg;
    assign word.rs         = (cmd_reg == CMD_WR_DATA) || (cmd_reg == CMD_DECIMAL)
                             || (cmd_reg == CMD_BINARY);
    assign word.data       = (state_reg == ST_DIGITS) ? (ASCII_ZERO | {4'b0000, bcd_digit})
                                                      : list_byte;
    assign word.wait_first = (state_reg == ST_LIST) && (cmd_reg == CMD_INIT) && (step_reg == '0);
    assign word.last       = (state_reg == ST_DIGITS) ? (dig_reg == '0) : last_step;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dig_next   = dig_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req_ok)
                begin
                    step_next  = '0;
                    dig_next   = DIG_IDX_W'(BCD_DIGITS - 1);
                    state_next = (request.command == CMD_DECIMAL) ? ST_CONV : ST_LIST;
                end
            end
            ST_LIST:
            begin
                if (word_fire)
                begin
                    if (last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_CONV:
            begin
                if (!bcd_busy)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // above the kept digits: a nonzero digit means the number is cut
                // short, so all kept digits print, zeros included
                if (int'(dig_reg) >= NDIG)
                begin
                    if (bcd_digit != 4'd0)
                    begin
                        dig_next   = DIG_IDX_W'(NDIG - 1);
                        state_next = ST_DIGITS;
                    end
                    else
                    begin
                        dig_next = dig_reg - 1'b1;
                    end
                end
                // drop leading zeros, keep at least one digit
                else if ((dig_reg != '0) && (bcd_digit == 4'd0))
                begin
                    dig_next = dig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (word_fire)
                begin
                    if (dig_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = dig_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dig_reg   <= dig_next;
        end
    end

    // request fields held for the whole request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg  <= request.command;
            disp_reg <= request.display;
            val_reg  <= request.byte_value;
            row_reg  <= request.row;
            col_reg  <= request.column;
        end
    end

`ifndef NO_ASSERTIONS
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DIGITS) |-> !bcd_busy)
        else $error("digits read while conversion still running");

    a_digit_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DIGITS) |-> (bcd_digit <= 4'd9))
        else $error("converter produced a digit above nine");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (word_fire && word.last) |=> request.ready)
        else $error("sequencer not idle after final word");

    a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !req_ok) |=> (request.ready && !word_valid))
        else $error("dropped request started a sequence");
`endif

endmodule
